// ----- src/wer_pkg.sv -----
// Shared types, constants and saturation helper for the wave equation row solver.
// No dependencies; used by wer_mul, wer_div and wave_equation_row_solver_top.
package wer_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PIDX_W     = $clog2(MAX_POINTS);
  localparam int PCNT_W     = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W     = PIDX_W + 1;
  localparam int MEM_DEPTH  = 2 * MAX_POINTS;

  localparam int DIV_NUM_W  = 34;
  localparam int DIV_DVD_W  = DIV_NUM_W + 24;
  localparam int DIV_STEPS  = DIV_DVD_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef logic signed [31:0] q_t;

  localparam q_t Q_ONE = 32'sh0100_0000;
  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    CFG_GRID_START  = 3'd0,
    CFG_GRID_STEP   = 3'd1,
    CFG_TIME_STEP   = 3'd2,
    CFG_SPEED_B     = 3'd3,
    CFG_POINT_COUNT = 3'd4,
    CFG_ROW_COUNT   = 3'd5
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PRE_T, ST_PRE_T1, ST_PRE_BT, ST_PRE_TAU, ST_PRE_HH, ST_PRE_R, ST_PRE_RW,
    ST_PRE_C, ST_PRE_NUM,
    ST_B0, ST_RB, ST_BW,
    ST_X0, ST_X1, ST_XB, ST_XS, ST_XS1, ST_XD, ST_XV,
    ST_I0, ST_I1, ST_I2, ST_I3, ST_I4, ST_IW, ST_I5, ST_I6, ST_I7, ST_I8,
    ST_EMIT
  } state_t;

  function automatic q_t sat_q(input logic signed [63:0] v);
    if (v > 64'(Q_MAX)) return Q_MAX;
    if (v < 64'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

endpackage

// ----- src/wer_mul.sv -----
// Shared Q8.24 multiplier: registered 32x32 product, floor shift and saturation.
// Depends on wer_pkg.
module wer_mul (
  input  logic          clk,
  input  wer_pkg::q_t   a,
  input  wer_pkg::q_t   b,
  output wer_pkg::q_t   q,
  output logic signed [47:0] raw
);

  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 64'(a) * 64'(b);
  end

  assign q   = wer_pkg::sat_q(64'(prod_r >>> 24));
  assign raw = prod_r[47:0];

endmodule

// ----- src/wer_div.sv -----
// Iterative Q8.24 divider, two quotient bits per cycle, saturating, zero-safe.
// Depends on wer_pkg.
module wer_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               go,
  input  logic signed [wer_pkg::DIV_NUM_W-1:0] num,
  input  wer_pkg::q_t                        den,
  output logic                               done,
  output wer_pkg::q_t                        q
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [wer_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [wer_pkg::DIV_DVD_W-1:0]     dvd_r, dvd_nxt, step_dvd;
  logic [32:0]                       rem_r, rem_nxt, step_rem;
  logic [31:0]                       dmag_r, dmag_nxt;
  logic                              neg_r, neg_nxt, nneg_r, nneg_nxt, zero_r, zero_nxt;
  wer_pkg::q_t                       q_r, q_nxt, fin_q;
  logic [wer_pkg::DIV_NUM_W-1:0]     nmag;

  always_comb begin
    step_dvd = dvd_r;
    step_rem = rem_r;
    for (int k = 0; k < 2; k++) begin
      step_rem = {step_rem[31:0], step_dvd[wer_pkg::DIV_DVD_W-1]};
      step_dvd = {step_dvd[wer_pkg::DIV_DVD_W-2:0], 1'b0};
      if (step_rem >= {1'b0, dmag_r}) begin
        step_rem    = step_rem - {1'b0, dmag_r};
        step_dvd[0] = 1'b1;
      end
    end
  end

  always_comb begin
    if (zero_r) begin
      fin_q = nneg_r ? wer_pkg::Q_MIN : wer_pkg::Q_MAX;
    end else if (neg_r) begin
      fin_q = (step_dvd > wer_pkg::DIV_DVD_W'(33'h1_0000_0000 >> 1)) ? wer_pkg::Q_MIN :
              -$signed(step_dvd[31:0]);
    end else begin
      fin_q = (step_dvd > wer_pkg::DIV_DVD_W'(32'h7FFF_FFFF)) ? wer_pkg::Q_MAX :
              $signed(step_dvd[31:0]);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    nneg_nxt = nneg_r;
    zero_nxt = zero_r;
    q_nxt    = q_r;
    nmag     = num[wer_pkg::DIV_NUM_W-1] ? wer_pkg::DIV_NUM_W'(-num) : wer_pkg::DIV_NUM_W'(num);
    if (busy_r) begin
      dvd_nxt = step_dvd;
      rem_nxt = step_rem;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        q_nxt    = fin_q;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end else if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = wer_pkg::DIV_CNT_W'(wer_pkg::DIV_STEPS - 1);
      dvd_nxt  = {nmag, 24'd0};
      rem_nxt  = '0;
      dmag_nxt = den[31] ? 32'(-den) : 32'(den);
      neg_nxt  = num[wer_pkg::DIV_NUM_W-1] ^ den[31];
      nneg_nxt = num[wer_pkg::DIV_NUM_W-1];
      zero_nxt = (den == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
    nneg_r <= nneg_nxt;
    zero_r <= zero_nxt;
    q_r    <= q_nxt;
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ----- src/wave_equation_row_solver_top.sv -----
// Top level: config registers, row sequencer, two-bank row memory.
// Depends on wer_pkg, wer_mul and wer_div.
// Each request yields one time row, one strobed point at a time; the receiver cannot stall,
// so a result must be taken in its cycle. busy is high from the cycle after acceptance until
// the last point appears. Rows 0 and 1 are computed point by point from the grid position;
// later rows first run a setup phase, then need one division for each boundary point and
// combine the two previous rows with a forcing term for each interior point. All rows share
// the single divider and the single multiplier. A past-end request gives one result in the
// cycle after acceptance and never raises busy.
module wave_equation_row_solver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_restart,
  output logic        out_valid,
  output logic [15:0] out_row_index,
  output logic [5:0]  out_point_index,
  output logic signed [31:0] out_value,
  output logic        out_last_of_row,
  output logic        out_past_end,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef logic [wer_pkg::PIDX_W-1:0] pidx_t;

  wer_pkg::q_t gs_r, b_r;
  logic [30:0] h_r, tau_r;
  logic [6:0]  pc_r;
  logic [15:0] rc_r;

  wer_pkg::state_t state_r, state_nxt;
  logic [15:0] row_r, row_nxt, next_row_r, next_row_nxt;
  logic        bank_r, bank_nxt;
  pidx_t       j_r, j_nxt;
  logic [wer_pkg::PCNT_W-1:0] m_r, m_nxt;
  wer_pkg::q_t t_r, t_nxt, bt_r, bt_nxt, tau2_r, tau2_nxt, r_r, r_nxt, c_r, c_nxt;
  wer_pkg::q_t num_r, num_nxt, s_r, s_nxt, base_r, base_nxt, val_r, val_nxt;
  logic signed [35:0] acc_r, acc_nxt;

  logic        ov_r, ov_nxt, olast_r, olast_nxt, opast_r, opast_nxt;
  logic [15:0] orow_r, orow_nxt;
  logic [5:0]  opt_r, opt_nxt;
  wer_pkg::q_t oval_r, oval_nxt;

  wer_pkg::q_t mem [wer_pkg::MEM_DEPTH];
  wer_pkg::q_t mem_q_r;
  logic [wer_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic        wr_en;

  wer_pkg::q_t mul_a, mul_b, mul_q;
  logic signed [47:0] mul_raw;
  logic        div_go, div_done;
  logic signed [wer_pkg::DIV_NUM_W-1:0] div_num;
  wer_pkg::q_t div_den, div_q;

  wer_pkg::q_t h_q, tau_q, x_v;
  logic [wer_pkg::PCNT_W-1:0] m_calc;
  logic [15:0] n_calc, i_calc;
  pidx_t       j_inc;

  wer_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .q(mul_q), .raw(mul_raw));

  wer_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .q(div_q)
  );

  assign h_q   = $signed({1'b0, h_r});
  assign tau_q = $signed({1'b0, tau_r});
  assign x_v   = wer_pkg::sat_q(64'(gs_r) + 64'(mul_raw));
  assign j_inc = j_r + 1'b1;

  always_comb begin
    if (pc_r < 7'd3) m_calc = wer_pkg::PCNT_W'(3);
    else if (32'(pc_r) > wer_pkg::MAX_POINTS) m_calc = wer_pkg::PCNT_W'(wer_pkg::MAX_POINTS);
    else m_calc = wer_pkg::PCNT_W'(pc_r);
    n_calc = (rc_r < 16'd2) ? 16'd2 : rc_r;
    i_calc = in_restart ? 16'd0 : next_row_r;
  end

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    next_row_nxt = next_row_r;
    bank_nxt     = bank_r;
    j_nxt        = j_r;
    m_nxt        = m_r;
    t_nxt        = t_r;
    bt_nxt       = bt_r;
    tau2_nxt     = tau2_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    num_nxt      = num_r;
    s_nxt        = s_r;
    base_nxt     = base_r;
    val_nxt      = val_r;
    acc_nxt      = acc_r;
    ov_nxt       = 1'b0;
    olast_nxt    = olast_r;
    opast_nxt    = opast_r;
    orow_nxt     = orow_r;
    opt_nxt      = opt_r;
    oval_nxt     = oval_r;
    mul_a        = '0;
    mul_b        = '0;
    div_go       = 1'b0;
    div_num      = '0;
    div_den      = '0;
    rd_addr      = {bank_r, j_r};
    wr_addr      = {~bank_r, j_r};
    wr_en        = 1'b0;

    unique case (state_r)
      wer_pkg::ST_IDLE: begin
        if (start) begin
          if (in_restart) next_row_nxt = 16'd0;
          if (i_calc >= n_calc) begin
            ov_nxt    = 1'b1;
            orow_nxt  = i_calc;
            opt_nxt   = '0;
            oval_nxt  = '0;
            olast_nxt = 1'b0;
            opast_nxt = 1'b1;
          end else begin
            row_nxt   = i_calc;
            m_nxt     = m_calc;
            j_nxt     = '0;
            state_nxt = (i_calc < 16'd2) ? wer_pkg::ST_X0 : wer_pkg::ST_PRE_T;
          end
        end
      end
      wer_pkg::ST_PRE_T: begin
        mul_a     = $signed({16'd0, row_r});
        mul_b     = tau_q;
        state_nxt = wer_pkg::ST_PRE_T1;
      end
      wer_pkg::ST_PRE_T1: begin
        t_nxt     = wer_pkg::sat_q(64'(mul_raw));
        state_nxt = wer_pkg::ST_PRE_BT;
      end
      wer_pkg::ST_PRE_BT: begin
        mul_a     = b_r;
        mul_b     = t_r;
        state_nxt = wer_pkg::ST_PRE_TAU;
      end
      wer_pkg::ST_PRE_TAU: begin
        bt_nxt    = mul_q;
        mul_a     = tau_q;
        mul_b     = tau_q;
        state_nxt = wer_pkg::ST_PRE_HH;
      end
      wer_pkg::ST_PRE_HH: begin
        tau2_nxt  = mul_q;
        mul_a     = h_q;
        mul_b     = h_q;
        state_nxt = wer_pkg::ST_PRE_R;
      end
      wer_pkg::ST_PRE_R: begin
        div_go    = 1'b1;
        div_num   = wer_pkg::DIV_NUM_W'(tau2_r);
        div_den   = mul_q;
        state_nxt = wer_pkg::ST_PRE_RW;
      end
      wer_pkg::ST_PRE_RW: begin
        if (div_done) begin
          r_nxt     = div_q;
          state_nxt = wer_pkg::ST_PRE_C;
        end
      end
      wer_pkg::ST_PRE_C: begin
        c_nxt     = wer_pkg::sat_q((64'(wer_pkg::Q_ONE) - 64'(r_r)) <<< 1);
        mul_a     = b_r;
        mul_b     = b_r;
        state_nxt = wer_pkg::ST_PRE_NUM;
      end
      wer_pkg::ST_PRE_NUM: begin
        num_nxt   = wer_pkg::sat_q((64'(mul_q) - 64'(wer_pkg::Q_ONE)) <<< 1);
        state_nxt = wer_pkg::ST_B0;
      end
      wer_pkg::ST_B0: begin
        div_go    = 1'b1;
        div_num   = wer_pkg::DIV_NUM_W'(wer_pkg::Q_ONE);
        div_den   = wer_pkg::sat_q(64'(wer_pkg::Q_ONE) + 64'(bt_r));
        state_nxt = wer_pkg::ST_BW;
      end
      wer_pkg::ST_RB: begin
        div_go    = 1'b1;
        div_num   = wer_pkg::DIV_NUM_W'(wer_pkg::Q_ONE);
        div_den   = wer_pkg::sat_q((64'(wer_pkg::Q_ONE) <<< 1) + 64'(bt_r));
        state_nxt = wer_pkg::ST_BW;
      end
      wer_pkg::ST_BW: begin
        if (div_done) begin
          val_nxt   = div_q;
          state_nxt = wer_pkg::ST_EMIT;
        end
      end
      wer_pkg::ST_X0: begin
        mul_a     = $signed(32'(j_r));
        mul_b     = h_q;
        state_nxt = wer_pkg::ST_X1;
      end
      wer_pkg::ST_X1: begin
        s_nxt     = wer_pkg::sat_q(64'(wer_pkg::Q_ONE) + 64'(x_v));
        div_go    = 1'b1;
        div_num   = wer_pkg::DIV_NUM_W'(wer_pkg::Q_ONE);
        div_den   = s_nxt;
        state_nxt = wer_pkg::ST_XB;
      end
      wer_pkg::ST_XB: begin
        if (div_done) begin
          base_nxt = div_q;
          if (row_r == 16'd0) begin
            val_nxt   = div_q;
            state_nxt = wer_pkg::ST_EMIT;
          end else begin
            state_nxt = wer_pkg::ST_XS;
          end
        end
      end
      wer_pkg::ST_XS: begin
        mul_a     = s_r;
        mul_b     = s_r;
        state_nxt = wer_pkg::ST_XS1;
      end
      wer_pkg::ST_XS1: begin
        div_go    = 1'b1;
        div_num   = -wer_pkg::DIV_NUM_W'(b_r);
        div_den   = mul_q;
        state_nxt = wer_pkg::ST_XD;
      end
      wer_pkg::ST_XD: begin
        mul_a = tau_q;
        mul_b = div_q;
        if (div_done) state_nxt = wer_pkg::ST_XV;
      end
      wer_pkg::ST_XV: begin
        val_nxt   = wer_pkg::sat_q(64'(mul_q) + 64'(base_r));
        state_nxt = wer_pkg::ST_EMIT;
      end
      wer_pkg::ST_I0: begin
        mul_a     = $signed(32'(j_r));
        mul_b     = h_q;
        state_nxt = wer_pkg::ST_I1;
      end
      wer_pkg::ST_I1: begin
        s_nxt     = wer_pkg::sat_q(64'(x_v) + 64'(bt_r) + 64'(wer_pkg::Q_ONE));
        state_nxt = wer_pkg::ST_I2;
      end
      wer_pkg::ST_I2: begin
        mul_a     = s_r;
        mul_b     = s_r;
        state_nxt = wer_pkg::ST_I3;
      end
      wer_pkg::ST_I3: begin
        mul_a     = mul_q;
        mul_b     = s_r;
        state_nxt = wer_pkg::ST_I4;
      end
      wer_pkg::ST_I4: begin
        div_go    = 1'b1;
        div_num   = wer_pkg::DIV_NUM_W'(num_r);
        div_den   = mul_q;
        state_nxt = wer_pkg::ST_IW;
      end
      wer_pkg::ST_IW: begin
        rd_addr = {bank_r, pidx_t'(j_r - 1'b1)};
        mul_a   = tau2_r;
        mul_b   = div_q;
        if (div_done) state_nxt = wer_pkg::ST_I5;
      end
      wer_pkg::ST_I5: begin
        acc_nxt   = 36'(mul_q);
        mul_a     = r_r;
        mul_b     = mem_q_r;
        rd_addr   = {bank_r, j_r};
        state_nxt = wer_pkg::ST_I6;
      end
      wer_pkg::ST_I6: begin
        acc_nxt   = acc_r + 36'(mul_q);
        mul_a     = c_r;
        mul_b     = mem_q_r;
        rd_addr   = {bank_r, j_inc};
        state_nxt = wer_pkg::ST_I7;
      end
      wer_pkg::ST_I7: begin
        acc_nxt   = acc_r + 36'(mul_q);
        mul_a     = r_r;
        mul_b     = mem_q_r;
        rd_addr   = {~bank_r, j_r};
        state_nxt = wer_pkg::ST_I8;
      end
      wer_pkg::ST_I8: begin
        val_nxt   = wer_pkg::sat_q(64'(acc_r) + 64'(mul_q) - 64'(mem_q_r));
        state_nxt = wer_pkg::ST_EMIT;
      end
      wer_pkg::ST_EMIT: begin
        wr_en     = 1'b1;
        ov_nxt    = 1'b1;
        orow_nxt  = row_r;
        opt_nxt   = 6'(j_r);
        oval_nxt  = val_r;
        opast_nxt = 1'b0;
        olast_nxt = (wer_pkg::PCNT_W'(j_r) == m_r - 1'b1);
        if (olast_nxt) begin
          bank_nxt     = ~bank_r;
          next_row_nxt = (row_r == 16'hFFFF) ? 16'hFFFF : row_r + 16'd1;
          state_nxt    = wer_pkg::ST_IDLE;
        end else begin
          j_nxt = j_inc;
          if (row_r < 16'd2) state_nxt = wer_pkg::ST_X0;
          else if (wer_pkg::PCNT_W'(j_inc) == m_r - 1'b1) state_nxt = wer_pkg::ST_RB;
          else state_nxt = wer_pkg::ST_I0;
        end
      end
      default: state_nxt = wer_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r       <= '0;
      h_r        <= 31'd1677722;
      tau_r      <= 31'd167772;
      b_r        <= 32'sd8388608;
      pc_r       <= 7'd11;
      rc_r       <= 16'd101;
      state_r    <= wer_pkg::ST_IDLE;
      next_row_r <= '0;
      bank_r     <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (wer_pkg::cfg_idx_t'(cfg_index))
          wer_pkg::CFG_GRID_START:  gs_r  <= $signed(cfg_data);
          wer_pkg::CFG_GRID_STEP:   h_r   <= cfg_data[30:0];
          wer_pkg::CFG_TIME_STEP:   tau_r <= cfg_data[30:0];
          wer_pkg::CFG_SPEED_B:     b_r   <= $signed(cfg_data);
          wer_pkg::CFG_POINT_COUNT: pc_r  <= cfg_data[6:0];
          wer_pkg::CFG_ROW_COUNT:   rc_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
      state_r    <= state_nxt;
      next_row_r <= next_row_nxt;
      bank_r     <= bank_nxt;
      ov_r       <= ov_nxt;
    end
    row_r   <= row_nxt;
    j_r     <= j_nxt;
    m_r     <= m_nxt;
    t_r     <= t_nxt;
    bt_r    <= bt_nxt;
    tau2_r  <= tau2_nxt;
    r_r     <= r_nxt;
    c_r     <= c_nxt;
    num_r   <= num_nxt;
    s_r     <= s_nxt;
    base_r  <= base_nxt;
    val_r   <= val_nxt;
    acc_r   <= acc_nxt;
    olast_r <= olast_nxt;
    opast_r <= opast_nxt;
    orow_r  <= orow_nxt;
    opt_r   <= opt_nxt;
    oval_r  <= oval_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= val_r;
    mem_q_r <= mem[rd_addr];
  end

  assign busy            = (state_r != wer_pkg::ST_IDLE);
  assign out_valid       = ov_r;
  assign out_row_index   = orow_r;
  assign out_point_index = opt_r;
  assign out_value       = oval_r;
  assign out_last_of_row = olast_r;
  assign out_past_end    = opast_r;

  a_accept_acts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted request produced neither work nor a result");

  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_row |-> !busy)
    else $error("sequencer still busy after last point");

  a_point_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_past_end |-> wer_pkg::PCNT_W'(out_point_index) < m_r)
    else $error("point index beyond row length");

  a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == wer_pkg::ST_PRE_RW || state_r == wer_pkg::ST_BW ||
                 state_r == wer_pkg::ST_XB || state_r == wer_pkg::ST_XD ||
                 state_r == wer_pkg::ST_IW)
    else $error("divider finished outside a wait state");

endmodule

// ----- verif/wave_equation_row_solver_top_tb.sv -----
// Self-checking testbench for wave_equation_row_solver_top: directed tables, then random
// row requests under random settings, each checked against an in-bench row predictor.
// Depends on wer_pkg and the solver RTL.
module wave_equation_row_solver_top_tb;

  localparam longint ONE  = 64'sd16777216;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  typedef struct packed {
    logic [15:0]        row;
    logic [5:0]         pt;
    logic signed [31:0] val;
    logic               last;
    logic               past;
  } point_t;

  typedef struct {
    bit          restart;
    bit          chk;
    logic [15:0] exp_row;
    longint      exp_val;
    bit          exp_past;
  } dir_req_t;

  logic clk, rst_n, start, busy, in_restart;
  logic out_valid, out_last_of_row, out_past_end;
  logic [15:0] out_row_index;
  logic [5:0] out_point_index;
  logic signed [31:0] out_value;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  wave_equation_row_solver_top u_dut (.*);

  point_t pending_q[$];
  point_t first_pred;
  int     errors = 0;

  longint x0_r, h_r, tau_r, b_r;
  int     npts_r, nrows_r;
  longint prev_row[wer_pkg::MAX_POINTS];
  longint older_row[wer_pkg::MAX_POINTS];
  int     next_row;
  bit     need_restart;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic longint sat32(input longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return sat32((a * b) >>> 24);
  endfunction

  function automatic longint qdiv(input longint a, input longint b);
    if (b == 0) return (a >= 0) ? QMAX : QMIN;
    return sat32((a * ONE) / b);
  endfunction

  function automatic longint recip1(input longint v);
    return qdiv(ONE, sat32(ONE + v));
  endfunction

  function automatic longint forcing(input longint x, input longint bt);
    longint num, s;
    num = sat32(2 * (qmul(b_r, b_r) - ONE));
    s = sat32(x + bt + ONE);
    return qdiv(num, qmul(qmul(s, s), s));
  endfunction

  task automatic predict_row(input bit restart);
    int m, n, i;
    longint nr[wer_pkg::MAX_POINTS];
    longint x, s, t, bt, tau2, r, c;
    point_t p;
    m = (npts_r < 3) ? 3 : (npts_r > wer_pkg::MAX_POINTS ? wer_pkg::MAX_POINTS : npts_r);
    n = (nrows_r < 2) ? 2 : nrows_r;
    if (restart) next_row = 0;
    if (next_row >= n) begin
      p = '{row: 16'(next_row), pt: '0, val: '0, last: 1'b0, past: 1'b1};
      first_pred = p;
      pending_q.push_back(p);
      return;
    end
    i = next_row;
    if (i < 2) begin
      for (int j = 0; j < m; j++) begin
        x = sat32(x0_r + j * h_r);
        if (i == 0) nr[j] = recip1(x);
        else begin
          s = sat32(ONE + x);
          nr[j] = sat32(qmul(tau_r, qdiv(-b_r, qmul(s, s))) + recip1(x));
        end
      end
    end else begin
      t = sat32(longint'(i) * tau_r);
      bt = qmul(b_r, t);
      tau2 = qmul(tau_r, tau_r);
      r = qdiv(tau2, qmul(h_r, h_r));
      c = sat32(2 * (ONE - r));
      nr[0] = recip1(bt);
      for (int j = 1; j + 1 < m; j++) begin
        x = sat32(x0_r + j * h_r);
        nr[j] = sat32(qmul(r, prev_row[j+1]) + qmul(c, prev_row[j]) + qmul(r, prev_row[j-1])
                      - older_row[j] + qmul(tau2, forcing(x, bt)));
      end
      nr[m-1] = qdiv(ONE, sat32(2 * ONE + bt));
    end
    for (int j = 0; j < m; j++) begin
      older_row[j] = prev_row[j];
      prev_row[j] = nr[j];
      p = '{row: 16'(i), pt: 6'(j), val: nr[j][31:0], last: (j + 1 == m), past: 1'b0};
      if (j == 0) first_pred = p;
      pending_q.push_back(p);
    end
    next_row = (i + 1) & 16'hFFFF;
    if (next_row == 0) next_row = 16'hFFFF;
  endtask

  always @(posedge clk) begin
    point_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) report("result with nothing pending");
      else begin
        e = pending_q.pop_front();
        if (out_row_index !== e.row || out_point_index !== e.pt || out_value !== e.val ||
            out_last_of_row !== e.last || out_past_end !== e.past)
          report($sformatf("got r%0d p%0d v%h l%b e%b, want r%0d p%0d v%h l%b e%b",
                 out_row_index, out_point_index, out_value, out_last_of_row, out_past_end,
                 e.row, e.pt, e.val, e.last, e.past));
      end
    end
  end

  task automatic cfg_write(input wer_pkg::cfg_idx_t idx, input longint v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v[31:0];
    case (idx)
      wer_pkg::CFG_GRID_START:  x0_r = longint'($signed(v[31:0]));
      wer_pkg::CFG_GRID_STEP:   h_r = v & 64'h7FFF_FFFF;
      wer_pkg::CFG_TIME_STEP:   tau_r = v & 64'h7FFF_FFFF;
      wer_pkg::CFG_SPEED_B:     b_r = longint'($signed(v[31:0]));
      wer_pkg::CFG_POINT_COUNT: begin
        npts_r = int'(v & 64'h7F);
        need_restart = 1;
      end
      wer_pkg::CFG_ROW_COUNT:   nrows_r = int'(v & 64'hFFFF);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_all(input longint x0, h, tau, b, input int np, nr);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write(wer_pkg::CFG_GRID_START, x0);
    cfg_write(wer_pkg::CFG_GRID_STEP, h);
    cfg_write(wer_pkg::CFG_TIME_STEP, tau);
    cfg_write(wer_pkg::CFG_SPEED_B, b);
    cfg_write(wer_pkg::CFG_POINT_COUNT, np);
    cfg_write(wer_pkg::CFG_ROW_COUNT, nr);
    cfg_we <= 1'b0;
  endtask

  // issue one request and wait until busy falls again; start stays high if no gap follows
  task automatic send_req(input bit rs, input int gap);
    start      <= 1'b1;
    in_restart <= rs;
    do @(posedge clk); while (busy);
    predict_row(rs);
    need_restart = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_gap(input bit quiet);
    if (quiet) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 300);
    return $urandom_range(0, 3);
  endfunction

  function automatic longint rnd_any();
    return longint'($signed($urandom()));
  endfunction

  dir_req_t dir_tab[] = '{
    '{1'b0, 1'b1, 16'd0, ONE, 1'b0},
    '{1'b0, 1'b0, 16'd1, 0, 1'b0},
    '{1'b0, 1'b0, 16'd2, 0, 1'b0},
    '{1'b0, 1'b0, 16'd3, 0, 1'b0},
    '{1'b1, 1'b1, 16'd0, ONE, 1'b0},
    '{1'b0, 1'b0, 16'd1, 0, 1'b0}
  };

  dir_req_t dir_short[] = '{
    '{1'b1, 1'b1, 16'd0, ONE, 1'b0},
    '{1'b0, 1'b0, 16'd1, 0, 1'b0},
    '{1'b0, 1'b1, 16'd2, 0, 1'b1},
    '{1'b0, 1'b1, 16'd2, 0, 1'b1},
    '{1'b1, 1'b1, 16'd0, ONE, 1'b0}
  };

  dir_req_t dir_sat[] = '{
    '{1'b1, 1'b1, 16'd0, QMAX, 1'b0},
    '{1'b0, 1'b0, 16'd1, 0, 1'b0},
    '{1'b0, 1'b0, 16'd2, 0, 1'b0}
  };

  task automatic run_table(input dir_req_t tab[]);
    foreach (tab[k]) begin
      send_req(tab[k].restart, pick_gap(0));
      if (tab[k].chk && (first_pred.row !== tab[k].exp_row ||
          first_pred.val !== tab[k].exp_val[31:0] ||
          first_pred.past !== tab[k].exp_past))
        report($sformatf("directed row %0d: predicted first point differs from table", k));
    end
  endtask

  initial begin
    int np, nr, cnt;
    bit quiet;
    rst_n = 0; start = 0; in_restart = 0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    x0_r = 0; h_r = 1677722; tau_r = 167772; b_r = 8388608;
    npts_r = 11; nrows_r = 101; next_row = 0; need_restart = 0;
    foreach (prev_row[k]) begin
      prev_row[k] = 0;
      older_row[k] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_table(dir_tab);
    set_all(0, ONE / 4, ONE / 16, ONE / 2, 3, 2);
    run_table(dir_short);
    // 1+x is zero at point 0: the quotient saturates
    set_all(-ONE, 1, QMAX, QMIN, wer_pkg::MAX_POINTS, 4);
    run_table(dir_sat);
    set_all(QMAX, QMAX, 1, QMAX, 5, 65535);
    send_req(1, 0); send_req(0, 0); send_req(0, 0); send_req(0, 2);

    cnt = 0;
    while (cnt < 230) begin
      case ($urandom_range(0, 3))
        0: set_all(rnd_any(), $urandom_range(1, 32'h7FFF_FFFF), $urandom_range(1, 32'h7FFF_FFFF),
                   rnd_any(), $urandom_range(3, 8), $urandom_range(2, 65535));
        default: set_all(longint'($urandom_range(0, 4 * ONE)) - ONE / 2,
                         $urandom_range(ONE / 64, ONE / 2), $urandom_range(ONE / 256, ONE / 8),
                         longint'($urandom_range(0, 4 * ONE)) - 2 * ONE,
                         ($urandom_range(0, 15) == 0) ? wer_pkg::MAX_POINTS :
                                                        $urandom_range(3, 10),
                         $urandom_range(2, 14));
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      nr = $urandom_range(6, 16);
      for (int k = 0; k < nr; k++) begin
        send_req(need_restart || $urandom_range(0, 11) == 0, pick_gap(quiet));
        cnt++;
      end
    end
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
